>>> rtl/tkf_pkg.sv
// ----------------------------------------------------------------------------
// Top-k sparsity filter package
// Shared widths, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tkf_pkg;

  // Width of the keep count register.
  localparam int unsigned KEEP_W = 7;

  // Configuration port widths.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index within the configuration space (byte address / 4).
  localparam logic [APB_ADDR_W-3:0] REG_KEEP_COUNT = '0;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SEEK    = 3'b010,
    ST_EMIT    = 3'b100
  } tkf_state_e;

  typedef struct packed {
    logic accept;  // take input items
    logic seek;    // walk the sorted chain toward the threshold entry
    logic emit;    // read back the store and send results
    logic clear;   // vector finished, return counters to zero
  } tkf_cmd_t;

  typedef struct packed {
    logic shift_done;
    logic emit_done;
  } tkf_status_t;

endpackage

>>> rtl/top_k_sparsity_filter_core.sv
// ----------------------------------------------------------------------------
// Top-k sparsity filter core
// Collects an activation vector, finds the keep_count largest units (ties to
// the lower index) and emits the vector in order with all other units zeroed.
//
//   Port group | Dir | Contents
//   s_axis     | in  | tdata: unit_value; tlast: last_unit
//   m_axis     | out | tdata: out_value; tlast: out_last; tuser: overflow
//   APB        | in  | 0x0: keep_count (7 bits, reset 1)
//
// Units are taken one per cycle while a vector is collected; a sorted
// insertion chain orders them as they arrive.
// After the last unit the controller walks the chain to the threshold entry,
// with keep_count - 1 chain shifts when 1 < keep_count < n and none otherwise.
// The n results then follow at one per cycle while the sink is ready, each
// through the store read and the output register; the vector closes when both are empty.
// No input is taken from the last unit until the vector has been closed.
// Reset is asynchronous and active low; it needs no clearing pass.
// ----------------------------------------------------------------------------
module top_k_sparsity_filter_core #(
  parameter int unsigned MAX_UNITS  = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i, // unit_value
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_axis_tdata_o, // out_value
  output logic                                  m_axis_tlast_o,
  output logic                                  m_axis_tuser_o, // overflow
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tkf_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [tkf_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [tkf_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import tkf_pkg::*;

  localparam int unsigned DW = ((VALUE_BITS + 7) / 8) * 8;

  logic [KEEP_W-1:0]     keep_count_q;
  logic                  cfg_sel;
  tkf_cmd_t              cmd;
  tkf_status_t           status;
  logic [VALUE_BITS-1:0] out_value;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_KEEP_COUNT);
  assign prdata  = cfg_sel ? APB_DATA_W'(keep_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      keep_count_q <= pwdata[KEEP_W-1:0];
    end
  end

  tkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tkf_datapath #(
    .MAX_UNITS  (MAX_UNITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .keep_count_i   (keep_count_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_value_i     (s_axis_tdata_i[VALUE_BITS-1:0]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_value_o    (out_value),
    .out_last_o     (m_axis_tlast_o),
    .out_overflow_o (m_axis_tuser_o)
  );

  assign s_axis_tready_o = cmd.accept;
  assign m_axis_tdata_o  = DW'(out_value);

endmodule

>>> rtl/tkf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module tkf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tkf_datapath.sv
// ----------------------------------------------------------------------------
// Top-k sparsity filter datapath
// Unit store, sorted insertion chain, threshold walk and the result pipeline
// (store read stage followed by the output register).
// ----------------------------------------------------------------------------
module tkf_datapath #(
  parameter int unsigned MAX_UNITS  = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tkf_pkg::tkf_cmd_t            cmd_i,
  output tkf_pkg::tkf_status_t         status_o,
  input  logic [tkf_pkg::KEEP_W-1:0]   keep_count_i,
  input  logic                         in_valid_i,
  input  logic [VALUE_BITS-1:0]        in_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [VALUE_BITS-1:0]        out_value_o,
  output logic                         out_last_o,
  output logic                         out_overflow_o
);
  import tkf_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_UNITS);
  localparam int unsigned CW   = $clog2(MAX_UNITS + 1);
  localparam int unsigned CMPW = (KEEP_W > CW) ? KEEP_W : CW;

  // Counters and flags.
  logic [CW-1:0]     units_seen_q, units_seen_d;
  logic              dropped_q, dropped_d;
  logic [KEEP_W-1:0] shift_cnt_q, shift_cnt_d;
  logic [CW-1:0]     issue_idx_q, issue_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [PW-1:0]     rd_idx_q;
  logic              out_vld_q, out_vld_d;
  logic [VALUE_BITS-1:0] out_val_q;
  logic              out_last_q;
  logic              out_ovf_q;

  // Sorted chain, highest value first; equal values stay in arrival order.
  logic signed [VALUE_BITS-1:0] lvl_q [MAX_UNITS];
  logic [PW-1:0]                pos_q [MAX_UNITS];
  logic [MAX_UNITS-1:0]         ge;

  logic                         in_fire;
  logic                         store_full;
  logic                         insert;
  logic                         shift;
  logic                         pass_all;
  logic                         keep_none;
  logic                         ld_out;
  logic                         issue;
  logic [VALUE_BITS-1:0]        ram_rdata;
  logic signed [VALUE_BITS-1:0] rd_val;
  logic                         keep_it;

  assign in_fire    = cmd_i.accept & in_valid_i;
  assign store_full = (units_seen_q == CW'(MAX_UNITS));
  assign insert     = in_fire & ~store_full;

  assign pass_all  = (CMPW'(keep_count_i) >= CMPW'(units_seen_q));
  assign keep_none = (keep_count_i == '0);

  // Chain entry k-1 reaches the head after k-1 shifts.
  assign status_o.shift_done = pass_all |
                               ((KEEP_W + 1)'(shift_cnt_q) + (KEEP_W + 1)'(1) >=
                                (KEEP_W + 1)'(keep_count_i));
  assign shift = cmd_i.seek & ~status_o.shift_done;

  for (genvar j = 0; j < MAX_UNITS; j++) begin : g_cell
    assign ge[j] = (CW'(j) < units_seen_q) && (lvl_q[j] >= $signed(in_value_i));

    always_ff @(posedge clk_i) begin
      if (insert && !ge[j]) begin
        if (j == 0) begin
          lvl_q[j] <= $signed(in_value_i);
          pos_q[j] <= units_seen_q[PW-1:0];
        end else if (ge[(j > 0) ? j - 1 : 0]) begin
          lvl_q[j] <= $signed(in_value_i);
          pos_q[j] <= units_seen_q[PW-1:0];
        end else begin
          lvl_q[j] <= lvl_q[(j > 0) ? j - 1 : 0];
          pos_q[j] <= pos_q[(j > 0) ? j - 1 : 0];
        end
      end else if (shift && (j < MAX_UNITS - 1)) begin
        lvl_q[j] <= lvl_q[(j < MAX_UNITS - 1) ? j + 1 : j];
        pos_q[j] <= pos_q[(j < MAX_UNITS - 1) ? j + 1 : j];
      end
    end
  end

  // Result pipeline: store read, then output register.
  assign ld_out = rd_vld_q & (~out_vld_q | out_ready_i);
  assign issue  = cmd_i.emit & (issue_idx_q != units_seen_q) & (~rd_vld_q | ld_out);

  tkf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_UNITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (insert),
    .waddr_i (units_seen_q[PW-1:0]),
    .wdata_i (in_value_i),
    .re_i    (issue),
    .raddr_i (issue_idx_q[PW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Survivors beat the threshold entry or tie it from a lower or equal index.
  assign rd_val  = $signed(ram_rdata);
  assign keep_it = pass_all |
                   (~keep_none & ((rd_val > lvl_q[0]) ||
                                  ((rd_val == lvl_q[0]) && (rd_idx_q <= pos_q[0]))));

  always_comb begin
    units_seen_d = units_seen_q;
    dropped_d    = dropped_q;
    shift_cnt_d  = shift_cnt_q;
    issue_idx_d  = issue_idx_q;
    if (insert) begin
      units_seen_d = units_seen_q + CW'(1);
    end
    if (in_fire && store_full) begin
      dropped_d = 1'b1;
    end
    if (shift) begin
      shift_cnt_d = shift_cnt_q + KEEP_W'(1);
    end
    if (issue) begin
      issue_idx_d = issue_idx_q + CW'(1);
    end
    if (cmd_i.clear) begin
      units_seen_d = '0;
      dropped_d    = 1'b0;
      shift_cnt_d  = '0;
      issue_idx_d  = '0;
    end
  end

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (issue) begin
      rd_vld_d = 1'b1;
    end else if (ld_out) begin
      rd_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (ld_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_seen_q <= '0;
      dropped_q    <= 1'b0;
      shift_cnt_q  <= '0;
      issue_idx_q  <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      units_seen_q <= units_seen_d;
      dropped_q    <= dropped_d;
      shift_cnt_q  <= shift_cnt_d;
      issue_idx_q  <= issue_idx_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= issue_idx_q[PW-1:0];
    end
    if (ld_out) begin
      out_val_q  <= keep_it ? ram_rdata : '0;
      out_last_q <= (CW'(rd_idx_q) + CW'(1) == units_seen_q);
      out_ovf_q  <= dropped_q;
    end
  end

  assign status_o.emit_done = (issue_idx_q == units_seen_q) & ~rd_vld_q & ~out_vld_q;

  assign out_valid_o    = out_vld_q;
  assign out_value_o    = out_val_q;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_ovf_q;

endmodule

>>> rtl/tkf_ctrl.sv
// ----------------------------------------------------------------------------
// Top-k sparsity filter controller
// Sequences collection of a vector, the threshold walk and the emission.
// ----------------------------------------------------------------------------
module tkf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  tkf_pkg::tkf_status_t status_i,
  output tkf_pkg::tkf_cmd_t    cmd_o
);
  import tkf_pkg::*;

  tkf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_COLLECT: begin
        cmd_o.accept = 1'b1;
        if (in_valid_i && in_last_i) begin
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        cmd_o.seek = 1'b1;
        if (status_i.shift_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_done) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> tb/top_k_sparsity_filter_core_tb.sv
// ----------------------------------------------------------------------------
// Top-k sparsity filter core testbench
// Streams activation vectors into the core and works out the masked vector for
// each one: the keep_count largest units keep their value, ties go to the
// lower index, and all other units read zero. Every output item is compared
// field by field. A short table of directed vectors runs first. Random vectors
// follow under several patterns of source gaps and sink back-pressure, with
// the keep count rewritten between vectors.
// ----------------------------------------------------------------------------
module top_k_sparsity_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkf_pkg::*;

  localparam int unsigned MaxUnits    = 64;
  localparam int unsigned ValueBits   = 16;
  localparam int          RandomItems = 270;

  // How a directed row is checked: by the predictor, or by a rule typed in.
  typedef enum logic [1:0] {
    RES_MODEL,
    RES_ZERO,
    RES_PASS
  } row_res_e;

  typedef struct packed {
    logic                      wr_keep;
    logic [KEEP_W-1:0]         keep;
    logic [2:0]                len;
    logic [0:5][ValueBits-1:0] vals;
    row_res_e                  res;
  } dir_row_t;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 last;
    logic                 ovf;
  } masked_t;

  localparam dir_row_t DirRows [8] = '{
    // Keep count still at its reset value; a one-unit vector passes.
    '{1'b0, 7'd1,   3'd1, '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      RES_PASS},
    // A keep count of zero clears every unit.
    '{1'b1, 7'd0,   3'd3, '{16'h8000, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000},
      RES_ZERO},
    // Keep counts at or above the store size act as the store size.
    '{1'b1, 7'd127, 3'd4, '{16'h1234, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000},
      RES_PASS},
    '{1'b1, 7'd64,  3'd2, '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      RES_PASS},
    // All units equal: only the first one survives.
    '{1'b1, 7'd1,   3'd4, '{16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0000, 16'h0000},
      RES_MODEL},
    '{1'b1, 7'd2,   3'd5, '{16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000},
      RES_MODEL},
    // Keep count equal to the vector length.
    '{1'b1, 7'd3,   3'd3, '{16'hAAAA, 16'h5555, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      RES_PASS},
    '{1'b1, 7'd2,   3'd3, '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
      RES_MODEL}
  };

  localparam int PhaseTxIdle [4]  = '{0, 48, 0, 21};
  localparam int PhaseRxStall [4] = '{0, 0, 48, 21};

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [ValueBits-1:0]  s_axis_tdata_i  = '0;  // unit_value
  logic                  s_axis_tlast_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [ValueBits-1:0]  m_axis_tdata_o;        // out_value
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;        // overflow
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [APB_ADDR_W-1:0] paddr           = '0;
  logic [APB_DATA_W-1:0] pwdata          = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int vectors_sent    = 0;
  int keep_writes     = 0;

  // Predictor state: the keep count as last written and the vector so far.
  logic [KEEP_W-1:0]    keep_mirror = KEEP_RESET;
  logic [ValueBits-1:0] vec_units [MaxUnits];
  int                   vec_len     = 0;
  logic                 vec_dropped = 1'b0;

  logic [ValueBits-1:0] stim_units [$];
  masked_t              masked_q [$];

  top_k_sparsity_filter_core #(
    .MAX_UNITS (MaxUnits),
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .m_axis_tuser_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d output items still outstanding.", masked_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Takes one accepted unit. On the last unit, ranks every stored unit by
  // value (ties to the lower index) and queues the masked vector.
  function automatic void mask_unit(input logic [ValueBits-1:0] unit_val, input logic last);
    int   k;
    int   rank;
    logic kept;
    if (vec_len < MaxUnits) begin
      vec_units[vec_len] = unit_val;
      vec_len++;
    end else begin
      vec_dropped = 1'b1;
    end
    if (last) begin
      k = (keep_mirror > MaxUnits) ? MaxUnits : int'(keep_mirror);
      for (int i = 0; i < vec_len; i++) begin
        rank = 0;
        for (int j = 0; j < vec_len; j++) begin
          if ($signed(vec_units[j]) > $signed(vec_units[i]) ||
              (vec_units[j] == vec_units[i] && j < i)) rank++;
        end
        kept = (k >= vec_len) || (rank < k);
        masked_q.push_back('{value: kept ? vec_units[i] : '0,
                             last:  (i == vec_len - 1),
                             ovf:   vec_dropped});
      end
      vec_len     = 0;
      vec_dropped = 1'b0;
    end
  endfunction

  task automatic send_unit(input logic [ValueBits-1:0] unit_val, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= unit_val;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_vector(input logic predict);
    foreach (stim_units[i]) begin
      send_unit(stim_units[i], i == stim_units.size() - 1);
      if (predict) mask_unit(stim_units[i], i == stim_units.size() - 1);
    end
    vectors_sent++;
  endtask

  // Waits until every queued output item has come back, then lets the core
  // close the vector before anything else is done.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_keep_count(input logic [KEEP_W-1:0] keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_KEEP_COUNT, 2'b00};
    pwdata  <= APB_DATA_W'(keep);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    keep_mirror = keep;
    keep_writes++;
    // Read the register straight back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(keep))
      note_failure($sformatf("keep_count read back: expected %0d, got %0d", keep, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep(input int len);
    case ($urandom_range(9))
      0:       return '0;
      1:       return KEEP_W'(MaxUnits);
      2:       return KEEP_W'($urandom_range(127));
      default: return KEEP_W'($urandom_range(len + 1));
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 12);
    return $urandom_range(13, MaxUnits);
  endfunction

  // Values come either fully random, from the extremes, or from a narrow
  // band so that ties are common.
  task automatic random_vector(input int len);
    int mode;
    mode = $urandom_range(2);
    stim_units = {};
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: stim_units.push_back(ValueBits'($urandom));
        1: begin
          case ($urandom_range(4))
            0:       stim_units.push_back(16'h8000);
            1:       stim_units.push_back(16'h7FFF);
            2:       stim_units.push_back(16'hFFFF);
            3:       stim_units.push_back(16'h0001);
            default: stim_units.push_back(16'h0000);
          endcase
        end
        default: stim_units.push_back(ValueBits'($urandom_range(8)) - ValueBits'(4));
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    masked_t want;
    m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (masked_q.size() == 0) begin
        note_failure($sformatf("Unexpected output item: value %0d last %0b overflow %0b",
                               $signed(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o));
      end else begin
        want = masked_q.pop_front();
        results_checked++;
        if (m_axis_tdata_o !== want.value || m_axis_tlast_o !== want.last ||
            m_axis_tuser_o !== want.ovf)
          note_failure($sformatf({"Output item %0d: expected value %0d last %0b overflow %0b,",
                                  " got value %0d last %0b overflow %0b"},
                                 results_checked, $signed(want.value), want.last, want.ovf,
                                 $signed(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o));
      end
    end
  end

  initial begin
    int phase_goal;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      if (DirRows[r].wr_keep) begin
        drain_results();
        write_keep_count(DirRows[r].keep);
      end
      stim_units = {};
      for (int i = 0; i < DirRows[r].len; i++) stim_units.push_back(DirRows[r].vals[i]);
      send_vector(DirRows[r].res == RES_MODEL);
      if (DirRows[r].res != RES_MODEL) begin
        foreach (stim_units[i])
          masked_q.push_back('{value: (DirRows[r].res == RES_PASS) ? stim_units[i] : '0,
                               last:  (i == stim_units.size() - 1),
                               ovf:   1'b0});
      end
    end

    phase_goal = items_sent;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      tx_idle_pct  = PhaseTxIdle[p];
      rx_stall_pct = PhaseRxStall[p];
      phase_goal  += RandomItems / 4;
      // Overrun the store: once with only the last unit dropped, once with more.
      if (p == 1 || p == 3) begin
        write_keep_count(pick_keep(MaxUnits));
        random_vector((p == 1) ? MaxUnits + 1 : MaxUnits + 3);
        send_vector(1'b1);
      end
      while (items_sent < phase_goal) begin
        len = pick_len();
        if ($urandom_range(2) == 0) begin
          drain_results();
          write_keep_count(pick_keep(len));
        end
        random_vector(len);
        send_vector(1'b1);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d units in %0d vectors across %0d keep_count settings.",
             items_sent, vectors_sent, keep_writes + 1);
    $display("Checked %0d output items; %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && masked_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tkf_pkg.sv
rtl/tkf_ram.sv
rtl/tkf_datapath.sv
rtl/tkf_ctrl.sv
rtl/top_k_sparsity_filter_core.sv
tb/top_k_sparsity_filter_core_tb.sv
